// File: sv/cle_pkg.sv
// Package for the console line editor: key codes, default line size and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int LINE_SIZE_DEF = 64;

  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_NL   = 8'h0A;
  localparam logic [7:0] KEY_EOT  = 8'h04;
  localparam logic [7:0] KEY_KILL = 8'h15;

  typedef struct packed {
    logic store;
    logic fill_dec;
    logic fill_clr;
    logic len_load;
    logic raw_load;
    logic rd_first;
    logic rd_next;
    logic out_raw;
    logic out_eof;
  } cle_cmd_t;

  typedef struct packed {
    logic raw_mode;
    logic is_bs;
    logic is_kill;
    logic is_nl;
    logic is_eot;
    logic fill_zero;
    logic fill_full;
    logic idx_last;
  } cle_status_t;

endpackage

`default_nettype wire

// File: sv/cle_datapath.sv
// Datapath of the console line editor: line store memory, fill count, read
// index, line length, raw byte hold and the mode register.
// Depends on cle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cle_datapath
  import cle_pkg::*;
#(
  parameter int LINE_SIZE = LINE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_data,
  input  wire logic [7:0]  key_byte,
  input  wire cle_cmd_t    cmd,
  output cle_status_t      status,
  output logic [7:0]       out_byte,
  output logic             has_byte
);

  localparam int IW = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
  localparam int LW = $clog2(LINE_SIZE + 1);

  logic [7:0]    mem [LINE_SIZE];
  logic [IW-1:0] fill;
  logic [IW-1:0] idx;
  logic [IW-1:0] rd_addr;
  logic [LW-1:0] len;
  logic [7:0]    rd_data;
  logic [7:0]    hold_byte;
  logic          raw_mode;

  assign rd_addr = cmd.rd_first ? '0 : IW'(idx + IW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
    end else if (cfg_valid) begin
      raw_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.fill_clr) begin
      fill <= '0;
    end else if (cmd.fill_dec) begin
      fill <= IW'(fill - IW'(1));
    end else if (cmd.store) begin
      fill <= IW'(fill + IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill] <= key_byte;
    end
    if (cmd.rd_first || cmd.rd_next) begin
      rd_data <= mem[rd_addr];
      idx     <= rd_addr;
    end
    if (cmd.len_load) begin
      len <= LW'(LW'(fill) + LW'(1) - LW'(status.is_eot));
    end
    if (cmd.raw_load) begin
      hold_byte <= key_byte;
    end
  end

  always_comb begin
    status.raw_mode  = raw_mode;
    status.is_bs     = (key_byte == KEY_BS);
    status.is_kill   = (key_byte == KEY_KILL);
    status.is_nl     = (key_byte == KEY_NL);
    status.is_eot    = (key_byte == KEY_EOT);
    status.fill_zero = (fill == '0);
    status.fill_full = (fill == IW'(LINE_SIZE - 1));
    status.idx_last  = ((LW'(idx) + LW'(1)) == len);
  end

  always_comb begin
    if (cmd.out_raw) begin
      out_byte = hold_byte;
    end else if (cmd.out_eof) begin
      out_byte = '0;
    end else begin
      out_byte = rd_data;
    end
    has_byte = !cmd.out_eof;
  end

endmodule

`default_nettype wire

// File: sv/cle_ctrl.sv
// Controller of the console line editor: decodes each accepted key against
// the datapath status and sequences line readout. Depends on cle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cle_ctrl
  import cle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic             m_tlast,
  input  wire cle_status_t status,
  output cle_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RAW  = 5'b00010,
    S_LOAD = 5'b00100,
    S_SEND = 5'b01000,
    S_EOF  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    m_tlast    = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (status.raw_mode) begin
            cmd.raw_load = 1'b1;
            state_next   = S_RAW;
          end else if (status.is_bs) begin
            cmd.fill_dec = !status.fill_zero;
          end else if (status.is_kill) begin
            cmd.fill_clr = 1'b1;
          end else begin
            cmd.store = 1'b1;
            if (status.is_nl || status.is_eot || status.fill_full) begin
              cmd.fill_clr = 1'b1;
              if (status.is_eot && status.fill_zero) begin
                state_next = S_EOF;
              end else begin
                cmd.len_load = 1'b1;
                state_next   = S_LOAD;
              end
            end
          end
        end
      end
      S_RAW: begin
        cmd.out_raw = 1'b1;
        m_tvalid    = 1'b1;
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.rd_first = 1'b1;
        state_next   = S_SEND;
      end
      S_SEND: begin
        m_tvalid = 1'b1;
        m_tlast  = status.idx_last;
        if (m_tready) begin
          if (status.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_EOF: begin
        cmd.out_eof = 1'b1;
        m_tvalid    = 1'b1;
        m_tlast     = 1'b1;
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/console_line_editor_core.sv
// Console line editor top level: controller plus datapath.
// Depends on cle_pkg, cle_ctrl and cle_datapath.
//
// Usage:
//   s_* takes one keyboard byte per request (s_tdata). cfg_* writes the
//   raw mode bit; cfg_ready is always high, write only while idle.
//   m_* delivers results: m_tdata is the byte, m_tuser is has_byte,
//   m_tlast marks the final result of a line.
// Sequencing and throughput:
//   Editing keys are accepted back to back. A raw byte is offered the cycle after
//   it is taken and the input reopens the cycle after it is delivered. For a
//   completed line of N bytes, S_LOAD reads the first byte from the line store's
//   registered read port, then S_SEND streams one byte per cycle while m_tready
//   is high; end of file is offered from S_EOF.
// Reset: clears mode (cooked), fill count and controller; store contents
//   are left as they are.
// Stall: while m_tready is low the result holds and no input is taken.
`timescale 1ns / 1ps
`default_nettype none

module console_line_editor_core
  import cle_pkg::*;
#(
  parameter int LINE_SIZE = LINE_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] key_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tuser,   // [0] has_byte
  output logic            m_tlast
);

  cle_cmd_t    cmd;
  cle_status_t status;

  assign cfg_ready = 1'b1;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  cle_datapath #(
    .LINE_SIZE (LINE_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .key_byte  (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_byte  (m_tdata),
    .has_byte  (m_tuser)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input open while a result is pending");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == 8'h00)))
    else $error("end of file result malformed");

  a_line_end_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not reopened after line end");

  a_raw_not_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && status.raw_mode) |=> (m_tvalid && m_tuser && !m_tlast))
    else $error("raw byte result malformed");

endmodule

`default_nettype wire

// File: bench/console_line_editor_core_tb.sv
// Self-checking bench for console_line_editor_core: line editing, end of file,
// full store and raw pass-through, with random stalls on both streams.
// Depends on cle_pkg and console_line_editor_core.
`timescale 1ns / 1ps

module console_line_editor_core_tb;
  import cle_pkg::*;

  localparam int STUCK_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_line;
  } line_result_t;

  typedef struct {
    logic [7:0] key;
    bit         pause;
  } key_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] key_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tuser;           // [0] has_byte
  logic       m_tlast;

  console_line_editor_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // editor mirror
  logic         raw_on;
  int           fill;
  logic [7:0]   line_buf [LINE_SIZE_DEF];
  line_result_t pending_lines [$];
  key_req_t     key_queue [$];

  bit          idle_on = 1'b1;
  bit          key_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          drained = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_draw;
  int          stuck = 0;
  int          fail_count = 0;
  int          keys_sent = 0;
  int          keys_queued = 0;
  int          results_seen = 0;
  int          lines_done = 0;
  int          eof_done = 0;
  int          raw_done = 0;
  key_req_t    next_req;

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic void edit_key(input logic [7:0] key);
    bit eol;
    int n;
    eol = 1'b0;
    if (raw_on) begin
      pending_lines.push_back('{key, 1'b1, 1'b0});
      raw_done++;
      return;
    end
    if (key == KEY_BS) begin
      if (fill > 0) fill--;
    end else if (key == KEY_KILL) begin
      fill = 0;
    end else begin
      eol = (key == KEY_NL) || (key == KEY_EOT);
      line_buf[fill] = key;
      fill++;
    end
    if (!eol && fill < LINE_SIZE_DEF) return;
    n = (key == KEY_EOT) ? fill - 1 : fill;
    fill = 0;
    if (n == 0) begin
      pending_lines.push_back('{8'h00, 1'b0, 1'b1});
      eof_done++;
    end else begin
      for (int i = 0; i < n; i++)
        pending_lines.push_back('{line_buf[i], 1'b1, i == n - 1});
      lines_done++;
    end
  endfunction

  function automatic void check_result();
    line_result_t want;
    results_seen++;
    if (pending_lines.size() == 0) begin
      $display("%0t: unexpected result out_byte %h has_byte %b last_of_line %b",
               $time, m_tdata, m_tuser, m_tlast);
      fail_count++;
      return;
    end
    want = pending_lines.pop_front();
    if (m_tdata !== want.out_byte) begin
      $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, m_tdata);
      fail_count++;
    end
    if (m_tuser !== want.has_byte) begin
      $display("%0t: has_byte expected %b actual %b", $time, want.has_byte, m_tuser);
      fail_count++;
    end
    if (m_tlast !== want.last_of_line) begin
      $display("%0t: last_of_line expected %b actual %b", $time, want.last_of_line, m_tlast);
      fail_count++;
    end
  endfunction

  // monitor, mirror update and watchdog
  always @(posedge clk) begin
    key_taken <= !rst && s_tvalid && s_tready;
    res_taken <= !rst && m_tvalid && m_tready;
    if (rst) begin
      raw_on = 1'b0;
      fill = 0;
      drained <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) raw_on = cfg_data;
      if (s_tvalid && s_tready) begin
        edit_key(s_tdata);
        keys_sent++;
      end
      if (m_tvalid && m_tready) check_result();
      drained <= key_queue.size() == 0 && (!s_tvalid || s_tready) &&
                 pending_lines.size() == 0;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stuck <= 0;
      else
        stuck <= stuck + 1;
      if (stuck == STUCK_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // key request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !key_taken) begin
      s_tvalid <= 1'b1;
    end else if (tx_gap != 0) begin
      s_tvalid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (key_queue.size() != 0 &&
                 !(key_queue[0].pause && pending_lines.size() != 0)) begin
      next_req = key_queue.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= next_req.key;
      tx_gap <= draw_wait();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (res_taken) begin
      rx_draw = draw_wait();
      if (rx_draw == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_stall <= rx_draw - 1;
      end
    end else if (rx_stall != 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void push_key(input logic [7:0] key, input bit pause = 1'b0);
    key_queue.push_back('{key, pause});
    keys_queued++;
  endfunction

  // one line of random content; terminator unless it fills the store
  function automatic void gen_line(input int len, input bit clean, input bit eot_end);
    int r;
    for (int i = 0; i < len; i++) begin
      r = clean ? 0 : $urandom_range(0, 99);
      if (r < 70)
        push_key(8'($urandom_range(8'h20, 8'h7E)), i == 0 && $urandom_range(0, 3) == 0);
      else if (r < 85)
        push_key(8'($urandom_range(0, 255)));
      else if (r < 95)
        push_key(KEY_BS);
      else
        push_key(KEY_KILL);
    end
    if (len < LINE_SIZE_DEF) push_key(eot_end ? KEY_EOT : KEY_NL, len == 0);
  endfunction

  task automatic wait_drained();
    @(posedge clk);
    @(negedge clk);
    while (!drained) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  int budget;

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // cooked editing cases
    push_key(KEY_BS);
    push_key(KEY_EOT);
    push_key(8'h00);
    push_key(8'hFF);
    push_key(KEY_NL);
    push_key(8'h78);
    push_key(KEY_BS);
    push_key(8'h79);
    push_key(KEY_KILL);
    push_key(8'h7A);
    push_key(KEY_EOT);
    push_key(KEY_NL, 1'b1);
    // partial line held across a spell in raw mode
    push_key(8'h61);
    push_key(8'h62);
    write_mode(1'b1);
    push_key(8'h00);
    push_key(8'hFF);
    push_key(KEY_BS);
    push_key(KEY_EOT);
    write_mode(1'b0);
    push_key(KEY_NL);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      idle_on = (ph != 3);
      if (ph == 2 || ph == 4) begin
        write_mode(1'b1);
        repeat (10) push_key(8'($urandom_range(0, 255)));
        write_mode(1'b0);
      end else begin
        if (ph == 1) gen_line(LINE_SIZE_DEF, 1'b1, 1'b0);
        if (ph == 5) gen_line(LINE_SIZE_DEF - 1, 1'b1, 1'b0);
        budget = keys_queued + 6;
        while (keys_queued < budget)
          gen_line($urandom_range(0, 12), 1'b0, $urandom_range(0, 1) != 0);
      end
    end

    wait_drained();
    repeat (16) @(negedge clk);
    $display("tb: %0d keys sent, %0d results checked (%0d lines, %0d end-of-file, %0d raw)",
             keys_sent, results_seen, lines_done, eof_done, raw_done);
    $display("tb: raw and cooked modes, full-store lines, stalls on both streams");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
